FILE: design/cppw_pkg.sv
// shared types and constants for the closest point proximity warning block
package cppw_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int DIST_WIDTH      = 16;
  localparam int RADIUS_WIDTH    = 15;
  localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 15'd1500;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_LOAD,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic out_free;
  } status_t;

endpackage

FILE: design/cppw_point_if.sv
// point input channel
interface cppw_point_if #(
  parameter int CW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] coord_x;
  logic signed [CW-1:0] coord_y;
  logic signed [CW-1:0] coord_z;
  logic                 point_valid;
  logic                 cloud_last;

  modport source (
    output valid, coord_x, coord_y, coord_z, point_valid, cloud_last,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, coord_z, point_valid, cloud_last,
    output ready
  );
endinterface

FILE: design/cppw_result_if.sv
// result output channel
interface cppw_result_if #(
  parameter int CW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic                 warn;
  logic                 found;
  logic signed [CW-1:0] near_x;
  logic signed [CW-1:0] near_y;
  logic signed [CW-1:0] near_z;
  logic [15:0]          near_distance;

  modport source (
    output valid, warn, found, near_x, near_y, near_z, near_distance,
    input  ready
  );
  modport sink (
    input  valid, warn, found, near_x, near_y, near_z, near_distance,
    output ready
  );
endinterface

FILE: design/cppw_root.sv
// iterative floor square root, one result bit per cycle while step is high
module cppw_root import cppw_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       step,
  input  logic [2*COORD_WIDTH-1:0]   operand,
  output logic [COORD_WIDTH-1:0]     root,
  output logic                       done
);
  localparam int SQ_W  = 2 * COORD_WIDTH;
  localparam int RM_W  = COORD_WIDTH + 2;
  localparam int CNT_W = $clog2(COORD_WIDTH + 1);

  logic [SQ_W-1:0]  op;
  logic [RM_W-1:0]  rem;
  logic [CNT_W-1:0] cnt;
  logic [RM_W+1:0]  rem_t;
  logic [RM_W+1:0]  trial;
  logic             ge;

  assign rem_t = {rem, op[SQ_W-1 -: 2]};
  assign trial = (RM_W+2)'({root, 2'b01});
  assign ge    = rem_t >= trial;
  assign done  = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(COORD_WIDTH);
    end else if (step && !done) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= operand;
      rem  <= '0;
      root <= '0;
    end else if (step && !done) begin
      op   <= op << 2;
      rem  <= ge ? RM_W'(rem_t - trial) : RM_W'(rem_t);
      root <= {root[COORD_WIDTH-2:0], ge};
    end
  end
endmodule

FILE: design/cppw_dp.sv
// datapath: squares, running minimum, warning flag, root and result register
module cppw_dp import cppw_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic                          cfg_wr_en,
  input  logic [RADIUS_WIDTH-1:0]       cfg_wr_data,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic                          in_pv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_warn,
  output logic                          out_found,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic [DIST_WIDTH-1:0]         out_dist
);
  localparam int SQ_W  = 2 * COORD_WIDTH;
  localparam int RSQ_W = 2 * RADIUS_WIDTH;
  localparam int CMP_W = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;

  logic [RADIUS_WIDTH-1:0] radius;
  logic [RSQ_W-1:0]        rsq;

  logic signed [SQ_W-1:0] prod_x, prod_y, prod_z;

  logic                          a_valid;
  logic                          a_pv;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic [SQ_W-1:0]               a_sqx, a_sqy, a_sqz;

  logic [SQ_W-1:0]               least;
  logic                          have_least;
  logic signed [COORD_WIDTH-1:0] best_x, best_y, best_z;
  logic                          warn_seen;

  logic                          r_warn, r_found;
  logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;

  logic [SQ_W-1:0]        dsq;
  logic                   better;
  logic                   in_range;
  logic [COORD_WIDTH-1:0] root;
  logic                   root_done;
  logic [DIST_WIDTH-1:0]  dist_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // radius squared registered off the multiplier
  always_ff @(posedge clk) begin
    rsq <= radius * radius;
  end

  assign prod_x = in_x * in_x;
  assign prod_y = in_y * in_y;
  assign prod_z = in_z * in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      a_pv  <= in_pv;
      a_x   <= in_x;
      a_y   <= in_y;
      a_z   <= in_z;
      a_sqx <= unsigned'(prod_x);
      a_sqy <= unsigned'(prod_y);
      a_sqz <= unsigned'(prod_z);
    end
  end

  // three squares of a COORD_WIDTH value never overflow 2*COORD_WIDTH bits
  assign dsq      = a_sqx + a_sqy + a_sqz;
  assign better   = !have_least || (dsq < least);
  assign in_range = CMP_W'(dsq) < CMP_W'(rsq);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      least      <= '0;
      have_least <= 1'b0;
      best_x     <= '0;
      best_y     <= '0;
      best_z     <= '0;
      warn_seen  <= 1'b0;
    end else if (a_valid && a_pv) begin
      if (better) begin
        least      <= dsq;
        have_least <= 1'b1;
        best_x     <= a_x;
        best_y     <= a_y;
        best_z     <= a_z;
      end
      if (in_range) begin
        warn_seen <= 1'b1;
      end
    end
  end

  // cloud snapshot held while the root runs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_warn  <= warn_seen;
      r_found <= have_least;
      r_x     <= best_x;
      r_y     <= best_y;
      r_z     <= best_z;
    end
  end

  cppw_root #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .step    (cmd.step),
    .operand (least),
    .root    (root),
    .done    (root_done)
  );

  generate
    if (COORD_WIDTH > DIST_WIDTH) begin : g_sat
      assign dist_sat = (|root[COORD_WIDTH-1:DIST_WIDTH]) ? '1 : root[DIST_WIDTH-1:0];
    end else begin : g_ext
      assign dist_sat = DIST_WIDTH'(root);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_warn  <= r_warn;
      out_found <= r_found;
      out_x     <= r_x;
      out_y     <= r_y;
      out_z     <= r_z;
      out_dist  <= dist_sat;
    end
  end

  assign status.root_done = root_done;
  assign status.out_free  = !out_valid || out_ready;
endmodule

FILE: design/cppw_ctrl.sv
// controller: point intake, cloud end sequencing and result hand-off
module cppw_ctrl import cppw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (in_valid && in_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROOT;
      ST_ROOT: begin
        if (status.root_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DRAIN: begin
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_ROOT: begin
        cmd.step = !status.root_done;
      end
      ST_OUT: begin
        cmd.publish = status.out_free;
      end
      default: begin
      end
    endcase
  end
endmodule

FILE: design/closest_point_proximity_warning_core.sv
// top level of the closest point proximity warning block
//
//   channel   dir  handshake          payload
//   points    in   valid / ready      coord_x, coord_y, coord_z, point_valid, cloud_last
//   results   out  valid / ready      warn, found, near_x, near_y, near_z, near_distance
//   cfg       in   cfg_wr_en          cfg_wr_data (alarm radius)
//
// one point beat per cycle inside a cloud; squares are registered, then summed and
// compared against the running minimum and the squared radius the next cycle.
// after the last beat of a cloud, points.ready stays low while the controller drains,
// loads the root unit, runs the bit-serial root and hands the result to the output
// register, waiting at that hand-off while the output register is full.
// rst is synchronous; the radius returns to 1500 and the cloud state is cleared.
// points are taken while an earlier result still waits in the output register.
module closest_point_proximity_warning_core import cppw_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [RADIUS_WIDTH-1:0] cfg_wr_data,
  cppw_point_if.sink              points,
  cppw_result_if.source           results
);
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign points.ready = in_ready;

  cppw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_last  (points.cloud_last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cppw_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_x        (points.coord_x),
    .in_y        (points.coord_y),
    .in_z        (points.coord_z),
    .in_pv       (points.point_valid),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_warn    (results.warn),
    .out_found   (results.found),
    .out_x       (results.near_x),
    .out_y       (results.near_y),
    .out_z       (results.near_z),
    .out_dist    (results.near_distance)
  );

  // intake stops right after the last beat of a cloud
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    points.valid && in_ready && points.cloud_last |=> !in_ready)
    else $error("point accepted after last beat of cloud");

  // an empty cloud reports no warning and a zero distance
  a_empty: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.found |-> !results.warn && results.near_distance == '0)
    else $error("empty cloud result not clean");

  // a result is only published while intake is closed
  a_publish: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !in_ready && !cmd.take)
    else $error("publish overlaps point intake");
endmodule

FILE: tb/proximity_checker.sv
`timescale 1ns / 1ps
// checker for the closest point proximity warning block: predicts each cloud summary and compares
module proximity_checker
  import cppw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [RADIUS_WIDTH-1:0] cfg_wr_data,
  cppw_point_if                   points,
  cppw_result_if                  results,
  output int                      mismatches,
  output int                      awaiting
);

  localparam int CW         = COORD_WIDTH_DEF;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic                 warn;
    logic                 found;
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic signed [CW-1:0] near_z;
    logic [DIST_WIDTH-1:0] near_distance;
  } cloud_summary_t;

  cloud_summary_t          summaries_due[$];

  logic [RADIUS_WIDTH-1:0] radius;
  logic [31:0]             least_sq;
  logic                    have_point;
  logic signed [CW-1:0]    best_x;
  logic signed [CW-1:0]    best_y;
  logic signed [CW-1:0]    best_z;
  logic                    warn_seen;

  function automatic logic [31:0] range_sq(input logic signed [CW-1:0] x,
                                           input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] z);
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    sx = 32'(x) * 32'(x);
    sy = 32'(y) * 32'(y);
    sz = 32'(z) * 32'(z);
    // three full squares can pass 2^31, so the sum is unsigned
    return $unsigned(sx) + $unsigned(sy) + $unsigned(sz);
  endfunction

  function automatic logic [DIST_WIDTH-1:0] floor_root(input logic [31:0] n);
    logic [DIST_WIDTH-1:0] root;
    logic [DIST_WIDTH-1:0] trial;
    root = '0;
    for (int b = DIST_WIDTH - 1; b >= 0; b--) begin
      trial = root | (DIST_WIDTH'(1) << b);
      if (32'(trial) * 32'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  function automatic cloud_summary_t close_cloud();
    cloud_summary_t s;
    s.warn          = warn_seen;
    s.found         = have_point;
    s.near_x        = have_point ? best_x : '0;
    s.near_y        = have_point ? best_y : '0;
    s.near_z        = have_point ? best_z : '0;
    s.near_distance = have_point ? floor_root(least_sq) : '0;
    return s;
  endfunction

  task automatic clear_cloud();
    least_sq   = '0;
    have_point = 1'b0;
    best_x     = '0;
    best_y     = '0;
    best_z     = '0;
    warn_seen  = 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input cloud_summary_t want,
                               input cloud_summary_t got);
    if (mismatches < SHOW_LIMIT) begin
      $display("[%0t] %s", $time, what);
      $display("  expected warn=%0b found=%0b near=(%0d,%0d,%0d) dist=%0d",
               want.warn, want.found, want.near_x, want.near_y, want.near_z,
               want.near_distance);
      $display("  actual   warn=%0b found=%0b near=(%0d,%0d,%0d) dist=%0d",
               got.warn, got.found, got.near_x, got.near_y, got.near_z,
               got.near_distance);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    cloud_summary_t got;
    cloud_summary_t want;
    logic [31:0]    dsq;
    logic [31:0]    rsq;
    if (rst) begin
      radius     = RADIUS_RESET;
      mismatches = 0;
      clear_cloud();
      summaries_due.delete();
    end else begin
      if (cfg_wr_en) radius = cfg_wr_data;

      // result beats first: a result never leaves in the cycle its last point enters
      if (results.valid && results.ready) begin
        got.warn          = results.warn;
        got.found         = results.found;
        got.near_x        = results.near_x;
        got.near_y        = results.near_y;
        got.near_z        = results.near_z;
        got.near_distance = results.near_distance;
        if (summaries_due.size() == 0) begin
          flag_mismatch("result beat with no cloud pending", '0, got);
        end else begin
          want = summaries_due.pop_front();
          if (got.warn !== want.warn || got.found !== want.found ||
              got.near_x !== want.near_x || got.near_y !== want.near_y ||
              got.near_z !== want.near_z || got.near_distance !== want.near_distance)
            flag_mismatch("cloud summary mismatch", want, got);
        end
      end

      if (points.valid && points.ready) begin
        if (points.point_valid) begin
          dsq = range_sq(points.coord_x, points.coord_y, points.coord_z);
          rsq = 32'(radius) * 32'(radius);
          // strict less-than keeps the earliest point on a tie
          if (!have_point || dsq < least_sq) begin
            least_sq   = dsq;
            have_point = 1'b1;
            best_x     = points.coord_x;
            best_y     = points.coord_y;
            best_z     = points.coord_z;
          end
          if (dsq < rsq) warn_seen = 1'b1;
        end
        if (points.cloud_last) begin
          summaries_due.push_back(close_cloud());
          clear_cloud();
        end
      end
    end
    awaiting = summaries_due.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench top for the closest point proximity warning block: stimulus and verdict
module testbench;
  import cppw_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int ROOT_CYCLES = CW + 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [RADIUS_WIDTH-1:0] cfg_wr_data = '0;

  int                      mismatches;
  int                      awaiting;
  int                      cycle_count = 0;
  int                      items_offered = 0;
  int                      current_radius = int'(RADIUS_RESET);
  bit                      sender_eager = 1'b0;
  bit                      hold_go = 1'b0;
  bit                      hold_done = 1'b0;

  cppw_point_if  #(.CW(CW)) points ();
  cppw_result_if #(.CW(CW)) results ();

  closest_point_proximity_warning_core #(.COORD_WIDTH(CW)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .points      (points),
    .results     (results)
  );

  proximity_checker cloud_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .points      (points),
    .results     (results),
    .mismatches  (mismatches),
    .awaiting    (awaiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] to_coord(input int v);
    if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
    if (v < int'(COORD_MIN)) v = int'(COORD_MIN);
    return CW'(v);
  endfunction

  function automatic int sender_gap();
    int roll;
    if (sender_eager) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int cloud_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 1;
    if (roll < 80) return $urandom_range(2, 12);
    if (roll < 95) return $urandom_range(13, 30);
    return $urandom_range(31, 64);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic offer_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z, input logic ok,
                             input logic last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    points.valid       <= 1'b1;
    points.coord_x     <= x;
    points.coord_y     <= y;
    points.coord_z     <= z;
    points.point_valid <= ok;
    points.cloud_last  <= last;
    do @(posedge clk); while (!points.ready);
    @(negedge clk);
    items_offered++;
  endtask

  task automatic write_radius(input int value);
    points.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    // let the root unit and output register settle before the write
    repeat (ROOT_CYCLES + 2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= RADIUS_WIDTH'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    current_radius = value;
  endtask

  task automatic play_cloud(input int len);
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] ax, ay, az;
    logic                 ok;
    int                   pick;
    int                   span;
    int                   edge_val;
    px = '0;
    py = '0;
    pz = '0;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      span = current_radius + current_radius / 4 + 4;
      if (i > 0 && pick < 15) begin
        // same distance as the previous valid point, signs and axes shuffled
        ax = $urandom_range(0, 1) ? -px : px;
        ay = $urandom_range(0, 1) ? -py : py;
        az = $urandom_range(0, 1) ? -pz : pz;
        if ($urandom_range(0, 1)) {ax, ay, az} = {ay, az, ax};
      end else if (pick < 40) begin
        ax = CW'($urandom);
        ay = CW'($urandom);
        az = CW'($urandom);
      end else if (pick < 55) begin
        // on or next to the warning sphere along one axis
        edge_val = current_radius + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) edge_val = -edge_val;
        ax = '0;
        ay = '0;
        az = '0;
        case ($urandom_range(0, 2))
          0:       ax = to_coord(edge_val);
          1:       ay = to_coord(edge_val);
          default: az = to_coord(edge_val);
        endcase
      end else begin
        ax = to_coord(int'($urandom_range(0, 2 * span)) - span);
        ay = to_coord(int'($urandom_range(0, 2 * span)) - span);
        az = to_coord(int'($urandom_range(0, 2 * span)) - span);
      end
      ok = ($urandom_range(0, 9) != 0);
      offer_point(ax, ay, az, ok, i == len - 1);
      if (ok) begin
        px = ax;
        py = ay;
        pz = az;
      end
    end
  endtask

  // result side: random ready with one long hold-off while the sender keeps pushing
  initial begin
    int run_len;
    int gap_len;
    int roll;
    results.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      results.ready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (run_len) @(negedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 40)      gap_len = 0;
      else if (roll < 80) gap_len = $urandom_range(1, 3);
      else if (roll < 95) gap_len = $urandom_range(4, 12);
      else                gap_len = $urandom_range(25, 70);
      if (gap_len > 0) begin
        results.ready <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
  end

  initial begin
    int target;
    points.valid       = 1'b0;
    points.coord_x     = '0;
    points.coord_y     = '0;
    points.coord_z     = '0;
    points.point_valid = 1'b0;
    points.cloud_last  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed clouds at the reset radius, then at a zero and a full-scale radius
    offer_point(COORD_MIN, COORD_MAX, 0, 1'b0, 1'b1);          // empty cloud
    offer_point(0, 0, 0, 1'b1, 1'b1);                           // origin
    offer_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);   // widest distance
    offer_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    offer_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    offer_point(3, 4, 0, 1'b1, 1'b0);
    offer_point(0, 0, 0, 1'b0, 1'b0);                           // missing point, ignored
    offer_point(-4, 3, 0, 1'b1, 1'b0);                          // tie, earlier kept
    offer_point(0, 0, 5, 1'b1, 1'b0);                           // tie again
    offer_point(1500, 0, 0, 1'b1, 1'b1);
    offer_point(1500, 0, 0, 1'b1, 1'b1);                        // exactly on the radius
    offer_point(0, -1499, 0, 1'b1, 1'b1);
    offer_point(866, 866, 866, 1'b1, 1'b1);
    offer_point(100, 200, 300, 1'b1, 1'b0);
    offer_point(0, 0, 0, 1'b0, 1'b1);                           // missing last beat
    write_radius(0);
    offer_point(0, 0, 0, 1'b1, 1'b1);                           // zero radius never warns
    write_radius(int'(COORD_MAX));
    offer_point(COORD_MIN, 0, 0, 1'b1, 1'b1);
    offer_point(32766, 0, 0, 1'b1, 1'b1);
    offer_point(0, 0, -32767, 1'b1, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_radius(1);
        1:       write_radius($urandom_range(0, 32767));
        2:       write_radius(int'(RADIUS_RESET));
        3:       write_radius($urandom_range(0, 3000));
        4:       write_radius(32767);
        default: write_radius($urandom_range(0, 32767));
      endcase
      if (phase == 2) begin
        // short back-to-back clouds while the result side holds off
        sender_eager = 1'b1;
        hold_go      = 1'b1;
        while (!hold_done) play_cloud($urandom_range(1, 4));
        sender_eager = 1'b0;
      end
      target = items_offered + PHASE_ITEMS;
      while (items_offered < target) begin
        sender_eager = ($urandom_range(0, 4) == 0);
        play_cloud(cloud_len());
      end
      sender_eager = 1'b0;
    end

    points.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (ROOT_CYCLES + 8) @(negedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
